### rtl/core/bsa_pkg.sv
package bsa_pkg;

    localparam int unsigned DEF_SLOT_COUNT = 16384;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned HANDLE_W = 15;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned BIT_W    = 6;
    localparam int unsigned GRP_SIZE = 32;
    localparam int unsigned GRP_SW   = 5;

    // stream widths
    localparam int unsigned IN_DATA_W = 16;
    localparam int unsigned OUT_W     = HANDLE_W + STATUS_W + HANDLE_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_CHECK = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_GRANT,
        RES_FULL,
        RES_OK,
        RES_INVALID
    } t_res;

    typedef struct packed {
        logic clear_step;   // write one word of the clearing pass
        logic capture;      // latch the accepted request
        logic grp_latch;    // latch first group with a free word
        logic word_read;    // read the first free word of that group
        logic handle_read;  // read the word that holds the handle
        logic alloc_commit; // clear the found bit, update summary and high water
        logic free_commit;  // set the handle bit, update summary and high water
        t_res res;          // result to record
        logic out_load;     // move the recorded result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic              clr_last;
        logic [FUNC_W-1:0] func;
        logic              handle_ok;
        logic              grp_found;
        logic              live;
    } t_dp_sts;

endpackage

### rtl/core/bsa_datapath.sv
module bsa_datapath
    import bsa_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [HANDLE_W-1:0] i_handle,
    output logic [OUT_W-1:0]    o_out_data
);

    localparam int unsigned MAP_WORDS  = SLOT_COUNT / WORD_W;
    localparam int unsigned SLOT_LIMIT = MAP_WORDS * WORD_W;
    localparam int unsigned WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned GROUPS_MIN = (MAP_WORDS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int unsigned GRP_AW     = (GROUPS_MIN > 1) ? $clog2(GROUPS_MIN) : 1;
    localparam int unsigned GROUPS     = 1 << GRP_AW;
    localparam int unsigned NZ_W       = GROUPS * GRP_SIZE;
    localparam int unsigned IDX_W      = WORD_AW + BIT_W + 1;
    localparam int unsigned CMP_W      = (IDX_W > HANDLE_W) ? IDX_W : HANDLE_W;

    // free map: set bit = free slot
    logic [WORD_W-1:0]   mem [MAP_WORDS];

    logic [FUNC_W-1:0]   r_func;
    logic [HANDLE_W-1:0] r_handle;
    logic [WORD_AW-1:0]  r_clr_addr;
    logic [NZ_W-1:0]     r_nz;          // word holds at least one free slot
    logic [GRP_AW-1:0]   r_grp;
    logic [WORD_AW-1:0]  r_word;
    logic [BIT_W-1:0]    r_bit;
    logic [WORD_W-1:0]   r_rd_data;
    logic [HANDLE_W-1:0] r_hw;
    logic [HANDLE_W-1:0] r_res_granted;
    t_status             r_res_status;
    logic [OUT_W-1:0]    r_out_data;

    logic [GROUPS-1:0]   grp_any;
    logic [GRP_AW-1:0]   grp_sel;
    logic                grp_found;
    logic [GRP_SIZE-1:0] sub_vec;
    logic [GRP_SW-1:0]   sub_sel;
    logic [WORD_AW-1:0]  alloc_word;
    logic [HANDLE_W-1:0] hm1;
    logic [WORD_AW-1:0]  h_word;
    logic                h_ok;
    logic [BIT_W-1:0]    low_bit;
    logic [IDX_W-1:0]    alloc_idx;
    logic [HANDLE_W-1:0] hw_alloc;
    logic                wr_en;
    logic [WORD_AW-1:0]  wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [WORD_W-1:0]   alloc_word_new;
    logic                rd_en;
    logic [WORD_AW-1:0]  rd_addr;

    // first group with any free word
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_any[g] = |r_nz[g*GRP_SIZE +: GRP_SIZE];
        end
        grp_sel = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                grp_sel = GRP_AW'(g);
            end
        end
        grp_found = |grp_any;
    end

    // first free word inside the latched group
    always_comb begin
        sub_vec = r_nz[r_grp*GRP_SIZE +: GRP_SIZE];
        sub_sel = '0;
        for (int s = GRP_SIZE - 1; s >= 0; s--) begin
            if (sub_vec[s]) begin
                sub_sel = GRP_SW'(s);
            end
        end
        alloc_word = WORD_AW'({r_grp, sub_sel});
    end

    // lowest free bit of the word just read
    always_comb begin
        low_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (r_rd_data[b]) begin
                low_bit = BIT_W'(b);
            end
        end
        alloc_idx      = IDX_W'({r_word, low_bit}) + IDX_W'(1);
        alloc_word_new = r_rd_data & ~(WORD_W'(1) << low_bit);
        hw_alloc       = (CMP_W'(alloc_idx) > CMP_W'(r_hw)) ? HANDLE_W'(alloc_idx) : r_hw;
    end

    assign hm1    = r_handle - HANDLE_W'(1);
    assign h_word = WORD_AW'(hm1 >> BIT_W);
    assign h_ok   = (r_handle != '0) && (32'(r_handle) <= 32'(SLOT_LIMIT));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_word;
        wr_data = r_rd_data;
        priority if (i_cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '1;
        end else if (i_cmd.alloc_commit) begin
            wr_en   = 1'b1;
            wr_data = alloc_word_new;
        end else if (i_cmd.free_commit) begin
            wr_en   = 1'b1;
            wr_data = r_rd_data | (WORD_W'(1) << r_bit);
        end
    end

    assign rd_en   = i_cmd.word_read | i_cmd.handle_read;
    assign rd_addr = i_cmd.word_read ? alloc_word : h_word;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_hw       <= '0;
            for (int i = 0; i < NZ_W; i++) begin
                r_nz[i] <= (i < MAP_WORDS);
            end
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + WORD_AW'(1);
            end
            if (i_cmd.alloc_commit) begin
                r_nz[r_word] <= |alloc_word_new;
                r_hw         <= hw_alloc;
            end else if (i_cmd.free_commit) begin
                r_nz[r_word] <= 1'b1;
                if (r_handle == r_hw) begin
                    r_hw <= r_hw - HANDLE_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_func;
            r_handle <= i_handle;
        end
        if (i_cmd.grp_latch) begin
            r_grp <= grp_sel;
        end
        if (i_cmd.word_read) begin
            r_word <= alloc_word;
        end else if (i_cmd.handle_read) begin
            r_word <= h_word;
            r_bit  <= hm1[BIT_W-1:0];
        end
        unique case (i_cmd.res)
            RES_GRANT: begin
                r_res_granted <= HANDLE_W'(alloc_idx);
                r_res_status  <= ST_OK;
            end
            RES_FULL: begin
                r_res_granted <= '0;
                r_res_status  <= ST_FULL;
            end
            RES_OK: begin
                r_res_granted <= '0;
                r_res_status  <= ST_OK;
            end
            RES_INVALID: begin
                r_res_granted <= '0;
                r_res_status  <= ST_INVALID;
            end
            default: begin
            end
        endcase
        // high water is already final here: one request in flight at a time
        if (i_cmd.out_load) begin
            r_out_data <= {r_hw, r_res_status, r_res_granted};
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == WORD_AW'(MAP_WORDS - 1));
    assign o_sts.func      = r_func;
    assign o_sts.handle_ok = h_ok;
    assign o_sts.grp_found = grp_found;
    assign o_sts.live      = ~r_rd_data[r_bit];
    assign o_out_data      = r_out_data;

endmodule

### rtl/core/bsa_ctrl.sv
module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WSEL,
        S_ALLOC,
        S_LOOKUP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = ~r_out_valid | i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res = RES_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.func)
                    FUNC_ALLOC: begin
                        o_cmd.grp_latch = 1'b1;
                        if (i_sts.grp_found) begin
                            n_state = S_WSEL;
                        end else begin
                            o_cmd.res = RES_FULL;
                            n_state   = S_DONE;
                        end
                    end
                    FUNC_FREE, FUNC_CHECK: begin
                        if (i_sts.handle_ok) begin
                            o_cmd.handle_read = 1'b1;
                            n_state           = S_LOOKUP;
                        end else begin
                            o_cmd.res = RES_INVALID;
                            n_state   = S_DONE;
                        end
                    end
                    default: begin
                        o_cmd.res = RES_INVALID;
                        n_state   = S_DONE;
                    end
                endcase
            end
            S_WSEL: begin
                o_cmd.word_read = 1'b1;
                n_state         = S_ALLOC;
            end
            S_ALLOC: begin
                o_cmd.alloc_commit = 1'b1;
                o_cmd.res          = RES_GRANT;
                n_state            = S_DONE;
            end
            S_LOOKUP: begin
                if (i_sts.live) begin
                    o_cmd.free_commit = (i_sts.func == FUNC_FREE);
                    o_cmd.res         = RES_OK;
                end else begin
                    o_cmd.res = RES_INVALID;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/bitmap_slot_allocator.sv
// Bitmap slot allocator: free map of 1-based slot handles, 64 slots per map word.
// Request channel (s_axis): tuser carries the function (allocate, free, check),
//   tdata the handle to free or check. Response channel (m_axis): one response
//   per request with granted handle, status and the high-water count after it.
// Steps from request accept to response load:
//   allocate: group search, word select and read, commit, response load;
//   free / check: decode and word read, test and commit, response load;
//   rejected handle, unknown function or full store: decode, response load.
//   One request is processed at a time; the next one is taken in the cycle after
//   the response is loaded. The free-map memory, with one read and one write port,
//   and the per-word summary flops set these steps.
// Reset: synchronous, active low. After reset the block runs a clearing pass
//   that writes every map word to all free; s_axis_tready stays low until it
//   ends. High water resets to zero.
// Stall: the response sits in an output register. While it waits the block
//   still takes and processes the next request, then holds that response until
//   the output register frees up.
module bitmap_slot_allocator
    import bsa_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_DATA_W-1:0] i_s_axis_tdata,   // [14:0] slot_handle
    input  logic [FUNC_W-1:0]    i_s_axis_tuser,   // [1:0] func
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata    // [14:0] granted_handle,
                                                   // [16:15] status, [31:17] high_water
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bsa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_func     (i_s_axis_tuser),
        .i_handle   (i_s_axis_tdata[HANDLE_W-1:0]),
        .o_out_data (o_m_axis_tdata)
    );

endmodule
